/* src/cda_pkg.sv */
// Shared types, constants and date helper functions for the calendar date adder.
package cda_pkg;

  // Operation codes carried in req_type
  localparam logic [1:0] REQ_ADD_DAYS   = 2'd0;
  localparam logic [1:0] REQ_ADD_MONTHS = 2'd1;
  localparam logic [1:0] REQ_ADD_YEARS  = 2'd2;
  localparam logic [1:0] REQ_NONE       = 2'd3;

  // Calendar constants
  localparam int unsigned YEAR_MAX      = 9999;
  localparam int unsigned MONTHS_PER_YR = 12;
  localparam int unsigned DW            = 17;  // working day width: 31 + 65535
  localparam int unsigned YW            = 17;  // working year width: 9999 + 65535

  // Reciprocal constants for division by 100 and by 12 (multiply, then shift)
  localparam int unsigned DIV100_MUL   = 5243;   // ceil(2^19 / 100)
  localparam int unsigned DIV12_MUL    = 43691;  // ceil(2^19 / 12)
  localparam int unsigned RECIP_SHIFT  = 19;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [13:0] start_year;
    logic [15:0] amount;
  } cda_in_t;

  typedef struct packed {
    logic [4:0]  new_day;
    logic [3:0]  new_month;
    logic [13:0] new_year;
    logic        input_valid;
    logic        result_valid;
    logic        year_overflow;
  } cda_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic check;
    logic step;
    logic mdiv;
    logic mapply;
    logic sat;
    logic finish;
  } cda_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic       in_ok;
    logic [1:0] op;
    logic       more_days;
    logic       year_roll;
  } cda_stat_t;

  // Length of a month; zero for a month code outside 1..12
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      4'd2:                                  len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:               len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10,
      4'd12:                                 len = 5'd31;
      default:                               len = 5'd0;
    endcase
    return len;
  endfunction

  // Full date check against the Gregorian rules
  function automatic logic date_ok(input logic [DW-1:0] d, input logic [3:0] m,
                                   input logic [YW-1:0] y, input logic leap);
    logic [4:0] len;
    len = month_len(m, leap);
    return (y <= YW'(YEAR_MAX)) && (len != 5'd0) && (d != '0) && (d <= DW'(len));
  endfunction

endpackage

/* src/cda_dp.sv */
// Datapath of the calendar date adder: date registers, leap flag, month stepper.
module cda_dp
  import cda_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cda_in_t   in_req,
  input  cda_cmd_t  cmd,
  output cda_stat_t stat,
  output logic      out_strobe,
  output cda_out_t  out_res
);

  logic [1:0]    op_r;
  logic [DW-1:0] d_r;
  logic [3:0]    m_r;
  logic [YW-1:0] y_r;
  logic [15:0]   amt_r;
  logic          leap_r;
  logic          ivalid_r;
  logic          ovf_r;
  logic [16:0]   t_r;
  logic [12:0]   q_r;
  cda_out_t      out_r;
  logic          out_strobe_r;

  // Leap flag of the current year, registered; valid in the cycle after a year update.
  // Only years below 16384 are ever looked at, so the low 14 bits suffice.
  logic [13:0] y14;
  logic [26:0] prod100;
  logic [7:0]  q100;
  logic [13:0] rem100;
  logic        leap_nxt;

  always_comb begin
    y14      = y_r[13:0];
    prod100  = 27'(y14) * 27'(DIV100_MUL);
    q100     = prod100[RECIP_SHIFT +: 8];
    rem100   = y14 - (14'(q100) * 14'd100);
    leap_nxt = (y14[1:0] == 2'b00) && ((rem100 != 14'd0) || (q100[1:0] == 2'b00));
  end

  always_ff @(posedge clk) begin
    leap_r <= leap_nxt;
  end

  // Month length and status for the controller
  logic [4:0] mlen;
  always_comb begin
    mlen            = month_len(m_r, leap_r);
    stat.in_ok      = date_ok(d_r, m_r, y_r, leap_r);
    stat.op         = op_r;
    stat.more_days  = d_r > DW'(mlen);
    stat.year_roll  = (m_r == 4'(MONTHS_PER_YR));
  end

  // Month division: t / 12 by reciprocal, remainder by shift-add
  logic [33:0] prod12;
  logic [16:0] rem12;
  always_comb begin
    prod12 = 34'(t_r) * 34'(DIV12_MUL);
    rem12  = t_r - ((17'(q_r) << 3) + (17'(q_r) << 2));
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_req.req_type;
      d_r      <= DW'(in_req.start_day);
      m_r      <= in_req.start_month;
      y_r      <= YW'(in_req.start_year);
      amt_r    <= in_req.amount;
      ivalid_r <= 1'b0;
      ovf_r    <= 1'b0;
    end
    if (cmd.check) begin
      ivalid_r <= stat.in_ok;
      if (stat.in_ok) begin
        case (op_r)
          REQ_ADD_DAYS:   d_r <= d_r + DW'(amt_r);
          REQ_ADD_MONTHS: t_r <= 17'(m_r) - 17'd1 + 17'(amt_r);
          REQ_ADD_YEARS:  y_r <= y_r + YW'(amt_r);
          default:        ;
        endcase
      end
    end
    // One month of day stepping
    if (cmd.step) begin
      d_r <= d_r - DW'(mlen);
      if (stat.year_roll) begin
        m_r <= 4'd1;
        y_r <= y_r + YW'(1);
      end else begin
        m_r <= m_r + 4'd1;
      end
    end
    if (cmd.mdiv) begin
      q_r <= prod12[RECIP_SHIFT +: 13];
    end
    if (cmd.mapply) begin
      m_r <= rem12[3:0] + 4'd1;
      y_r <= y_r + YW'(q_r);
    end
    // Year saturation
    if (cmd.sat && (y_r > YW'(YEAR_MAX))) begin
      y_r   <= YW'(YEAR_MAX);
      ovf_r <= 1'b1;
    end
    if (cmd.finish) begin
      out_r.new_day       <= d_r[4:0];
      out_r.new_month     <= m_r;
      out_r.new_year      <= y_r[13:0];
      out_r.input_valid   <= ivalid_r;
      out_r.result_valid  <= ivalid_r & date_ok(d_r, m_r, y_r, leap_r);
      out_r.year_overflow <= ovf_r;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.finish;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_r;

endmodule

/* src/cda_ctrl.sv */
// Controller state machine of the calendar date adder.
module cda_ctrl
  import cda_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  cda_stat_t stat,
  output logic      busy,
  output cda_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEAP_IN,
    S_CHECK,
    S_STEP,
    S_YEAR_WAIT,
    S_MDIV,
    S_MAPPLY,
    S_SAT,
    S_SAT_WAIT,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_LEAP_IN;
        end
      end
      S_LEAP_IN: state_nxt = S_CHECK;
      S_CHECK: begin
        cmd.check = 1'b1;
        if (!stat.in_ok) begin
          state_nxt = S_FINISH;
        end else begin
          unique case (stat.op)
            REQ_ADD_DAYS:   state_nxt = S_STEP;
            REQ_ADD_MONTHS: state_nxt = S_MDIV;
            REQ_ADD_YEARS:  state_nxt = S_SAT;
            REQ_NONE:       state_nxt = S_SAT;
            default:        state_nxt = S_SAT;
          endcase
        end
      end
      // One month per cycle; a year roll passes through S_YEAR_WAIT for the new leap flag
      S_STEP: begin
        if (stat.more_days) begin
          cmd.step  = 1'b1;
          state_nxt = stat.year_roll ? S_YEAR_WAIT : S_STEP;
        end else begin
          state_nxt = S_SAT;
        end
      end
      S_YEAR_WAIT: state_nxt = S_STEP;
      S_MDIV: begin
        cmd.mdiv  = 1'b1;
        state_nxt = S_MAPPLY;
      end
      S_MAPPLY: begin
        cmd.mapply = 1'b1;
        state_nxt  = S_SAT;
      end
      S_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = S_SAT_WAIT;
      end
      S_SAT_WAIT: state_nxt = S_FINISH;
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

/* src/calendar_date_adder_top.sv */
// Top level of the calendar date adder: controller plus datapath.
//
//   channel   ports                    handshake
//   request   start, busy, in_req      taken when start & !busy
//   result    out_strobe, out_res      one-cycle strobe, always taken
//
// An invalid input date goes from the check straight to finish; add-years and
// no operation pass through saturation and its wait state, add-months first
// through month division and apply, and add-days first through the month
// stepper, which bounds the day loop: one month per cycle, plus a wait state
// after each year roll to refresh the registered leap flag. Reset (rst_n low,
// synchronous) returns the controller to idle and drops the strobe. busy stays
// high until the cycle the result strobe is shown; the receiver cannot stall.
module calendar_date_adder_top
  import cda_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  cda_in_t  in_req,
  output logic     out_strobe,
  output cda_out_t out_res
);

  cda_cmd_t  cmd;
  cda_stat_t stat;

  // Sequencer
  cda_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Date registers and arithmetic
  cda_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule
